// ===== design/timu_pkg.sv =====
package timu_pkg;

   // configuration register indexes
   typedef enum logic [1:0] {
      CSR_TIMER_CONTROL    = 2'd0,
      CSR_TIMER_MODULO     = 2'd1,
      CSR_INTERRUPT_ENABLE = 2'd2
   } csr_index_type;

   // timer rate select codes
   localparam logic [1:0] RATE_1024 = 2'b00;
   localparam logic [1:0] RATE_16   = 2'b01;
   localparam logic [1:0] RATE_64   = 2'b10;
   localparam logic [1:0] RATE_256  = 2'b11;

   localparam int          SOURCE_COUNT   = 5;
   localparam logic [7:0]  TIMER_OVERFLOW = 8'hFF;
   localparam logic [6:0]  VECTOR_BASE    = 7'h40;
   localparam int          TIMER_ENABLE_BIT = 2;
   localparam int          TIMER_FLAG_BIT   = 2;

   // one result
   typedef struct packed {
      logic [7:0] divider_value;
      logic [7:0] timer_value;
      logic [4:0] flag_bits;
      logic       dispatch;
      logic [6:0] vector_address;
   } timu_result_type;

   // timer prescaler threshold for a rate select code
   function automatic logic [10:0] rate_threshold(input logic [1:0] sel);
      logic [10:0] thr;
      case (sel)
         RATE_1024: thr = 11'd1024;
         RATE_16:   thr = 11'd16;
         RATE_64:   thr = 11'd64;
         RATE_256:  thr = 11'd256;
         default:   thr = 11'd1024;
      endcase
      return thr;
   endfunction

endpackage

// ===== design/timu_if.sv =====
// CPU step request channel
interface timu_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] cycle_count;
   logic       master_enable;
   logic [4:0] new_requests;

   modport source (output valid, output cycle_count, output master_enable,
                   output new_requests, input ready);
   modport sink   (input valid, input cycle_count, input master_enable,
                   input new_requests, output ready);
endinterface

// step result channel
interface timu_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] divider_value;
   logic [7:0] timer_value;
   logic [4:0] flag_bits;
   logic       dispatch;
   logic [6:0] vector_address;

   modport source (output valid, output divider_value, output timer_value,
                   output flag_bits, output dispatch, output vector_address,
                   input ready);
   modport sink   (input valid, input divider_value, input timer_value,
                   input flag_bits, input dispatch, input vector_address,
                   output ready);
endinterface

// ===== design/timu_core.sv =====
module timu_core (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     accept,
   input  logic [7:0]               cycle_count,
   input  logic                     master_enable,
   input  logic [4:0]               new_requests,
   input  logic                     csr_write_enable,
   input  logic [1:0]               csr_index,
   input  logic [7:0]               csr_write_data,
   output timu_pkg::timu_result_type result
);
   import timu_pkg::*;

   logic [2:0]  timer_control_ff;
   logic [7:0]  timer_modulo_ff;
   logic [4:0]  interrupt_enable_ff;

   logic [8:0]  divider_prescale_ff, divider_prescale_in;
   logic [10:0] timer_prescale_ff, timer_prescale_in;
   logic [7:0]  divider_count_ff, divider_count_in;
   logic [7:0]  timer_count_ff, timer_count_in;
   logic [4:0]  pending_flags_ff, pending_flags_in;

   logic [8:0]  div_sum;
   logic [10:0] tim_sum;
   logic [4:0]  flags_raised;
   logic [4:0]  candidates;
   logic        taken;
   logic [6:0]  vector;

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         timer_control_ff    <= 3'd0;
         timer_modulo_ff     <= 8'd0;
         interrupt_enable_ff <= 5'd0;
      end else if (csr_write_enable) begin
         case (csr_index)
            CSR_TIMER_CONTROL:    timer_control_ff    <= csr_write_data[2:0];
            CSR_TIMER_MODULO:     timer_modulo_ff     <= csr_write_data;
            CSR_INTERRUPT_ENABLE: interrupt_enable_ff <= csr_write_data[4:0];
            default: ;
         endcase
      end
   end

   // pending flags, divider and timer prescalers and counters
   always_comb begin
      flags_raised       = pending_flags_ff | new_requests;
      div_sum            = divider_prescale_ff + {1'b0, cycle_count};
      divider_prescale_in = div_sum;
      divider_count_in   = divider_count_ff;
      if (div_sum[8]) begin
         divider_prescale_in = 9'd0;
         divider_count_in    = divider_count_ff + 8'd1;
      end

      tim_sum           = timer_prescale_ff + {3'b000, cycle_count};
      timer_prescale_in = timer_prescale_ff;
      timer_count_in    = timer_count_ff;
      if (timer_control_ff[TIMER_ENABLE_BIT]) begin
         timer_prescale_in = tim_sum;
         if (tim_sum >= rate_threshold(timer_control_ff[1:0])) begin
            timer_prescale_in = 11'd0;
            if (timer_count_ff == TIMER_OVERFLOW) begin
               timer_count_in               = timer_modulo_ff;
               flags_raised[TIMER_FLAG_BIT] = 1'b1;
            end else begin
               timer_count_in = timer_count_ff + 8'd1;
            end
         end
      end
   end

   // with master_enable set, the lowest enabled pending source wins
   always_comb begin
      candidates       = flags_raised & interrupt_enable_ff;
      taken            = 1'b0;
      vector           = 7'd0;
      pending_flags_in = flags_raised;
      if (master_enable) begin
         for (int i = 0; i < SOURCE_COUNT; i++) begin
            if (!taken && candidates[i]) begin
               taken               = 1'b1;
               vector              = VECTOR_BASE + {1'b0, 3'(i), 3'b000};
               pending_flags_in[i] = 1'b0;
            end
         end
      end
   end

   // state advances once per accepted request
   always_ff @(posedge clock) begin
      if (reset) begin
         divider_prescale_ff <= 9'd0;
         timer_prescale_ff   <= 11'd0;
         divider_count_ff    <= 8'd0;
         timer_count_ff      <= 8'd0;
         pending_flags_ff    <= 5'd0;
      end else if (accept) begin
         divider_prescale_ff <= divider_prescale_in;
         timer_prescale_ff   <= timer_prescale_in;
         divider_count_ff    <= divider_count_in;
         timer_count_ff      <= timer_count_in;
         pending_flags_ff    <= pending_flags_in;
      end
   end

   assign result.divider_value  = divider_count_in;
   assign result.timer_value    = timer_count_in;
   assign result.flag_bits      = pending_flags_in;
   assign result.dispatch       = taken;
   assign result.vector_address = vector;

   // timer prescaler never reaches the top of its range
   a_tim_prescale_range: assert property (@(posedge clock) disable iff (reset)
      timer_prescale_ff < 11'd1279)
      else $error("timer prescaler out of range");

   // a dispatched source is cleared in the next flags
   a_dispatch_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && taken) |=> ((pending_flags_ff & interrupt_enable_ff) !=
                             $past(flags_raised & interrupt_enable_ff)))
      else $error("dispatched flag not cleared");

   // disabled timer holds its prescaler and counter
   a_timer_hold: assert property (@(posedge clock) disable iff (reset)
      (accept && !timer_control_ff[TIMER_ENABLE_BIT] && !csr_write_enable) |=>
      ($stable(timer_prescale_ff) && $stable(timer_count_ff)))
      else $error("disabled timer moved");

endmodule

// ===== design/timu_out_queue.sv =====
module timu_out_queue (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      push,
   input  timu_pkg::timu_result_type push_data,
   output logic                      space,
   output logic                      head_valid,
   input  logic                      pop,
   output timu_pkg::timu_result_type head_data
);
   import timu_pkg::*;

   timu_result_type entry0_ff, entry0_in;
   timu_result_type entry1_ff, entry1_in;
   logic [1:0]      count_ff, count_in;

   // two-entry queue: head register plus skid entry
   always_comb begin
      entry0_in = entry0_ff;
      entry1_in = entry1_ff;
      count_in  = count_ff;
      case ({push, pop})
         2'b10: begin
            if (count_ff == 2'd0) entry0_in = push_data;
            else                  entry1_in = push_data;
            count_in = count_ff + 2'd1;
         end
         2'b01: begin
            entry0_in = entry1_ff;
            count_in  = count_ff - 2'd1;
         end
         2'b11: begin
            if (count_ff == 2'd1) begin
               entry0_in = push_data;
            end else begin
               entry0_in = entry1_ff;
               entry1_in = push_data;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= 2'd0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      entry0_ff <= entry0_in;
      entry1_ff <= entry1_in;
   end

   assign space      = (count_ff != 2'd2);
   assign head_valid = (count_ff != 2'd0);
   assign head_data  = entry0_ff;

   // occupancy stays within two entries
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff != 2'd3)
      else $error("queue count out of range");

   // push alone grows the queue by one
   a_push_grows: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> (count_ff == $past(count_ff) + 2'd1))
      else $error("queue did not grow on push");

   // head result carries a vector only when dispatched
   a_vector_zero: assert property (@(posedge clock) disable iff (reset)
      (head_valid && !entry0_ff.dispatch) |-> (entry0_ff.vector_address == 7'd0))
      else $error("vector without dispatch");

endmodule

// ===== design/timer_and_interrupt_unit.sv =====
// Channel   Direction  Handshake     Payload
// req_if    in         valid/ready   cycle_count, master_enable, new_requests
// rsp_if    out        valid/ready   divider_value, timer_value, flag_bits,
//                                    dispatch, vector_address
// csr_*     in         write enable  csr_index, csr_write_data
//
// One request per cycle while req_if.ready is high; its result is registered and
// appears the cycle after acceptance when no older result waits in the queue.
// Counters and flags update in the accepting cycle, set by one pass of prescaler
// add/compare and the priority pick. A two-entry output queue lets requests flow
// while rsp_if stalls; req_if.ready drops only when both entries hold results.
// Synchronous reset clears all state and configuration registers but the queue data.
module timer_and_interrupt_unit (
   input  logic        clock,
   input  logic        reset,
   timu_req_if.sink    req_if,
   timu_rsp_if.source  rsp_if,
   input  logic        csr_write_enable,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_write_data
);
   import timu_pkg::*;

   timu_result_type step_result;
   timu_result_type head_result;
   logic            accept;
   logic            space;
   logic            pop;

   assign req_if.ready = space;
   assign accept       = req_if.valid && space;
   assign pop          = rsp_if.valid && rsp_if.ready;

   timu_core u_core (
      .clock            (clock),
      .reset            (reset),
      .accept           (accept),
      .cycle_count      (req_if.cycle_count),
      .master_enable    (req_if.master_enable),
      .new_requests     (req_if.new_requests),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .result           (step_result)
   );

   timu_out_queue u_out_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (accept),
      .push_data  (step_result),
      .space      (space),
      .head_valid (rsp_if.valid),
      .pop        (pop),
      .head_data  (head_result)
   );

   assign rsp_if.divider_value  = head_result.divider_value;
   assign rsp_if.timer_value    = head_result.timer_value;
   assign rsp_if.flag_bits      = head_result.flag_bits;
   assign rsp_if.dispatch       = head_result.dispatch;
   assign rsp_if.vector_address = head_result.vector_address;

endmodule

// ===== verif/tb.sv =====
`timescale 1ns / 100ps

module tb;
   import timu_pkg::*;

   localparam int CYCLE_LIMIT   = 200000;
   localparam int DRAIN_CYCLES  = 4;
   localparam int RAND_PHASES   = 11;
   localparam int PHASE_STEPS   = 100;
   localparam int REPORT_LIMIT  = 10;

   // index with no register behind it
   localparam logic [1:0] CSR_UNMAPPED = 2'd3;

   typedef enum logic {ROW_STEP, ROW_CSR} row_kind_type;

   typedef struct {
      row_kind_type    kind;
      logic [1:0]      idx;
      logic [7:0]      val;
      logic            me;
      logic [4:0]      req;
      bit              known;
      timu_result_type res;
   } plan_row_type;

   logic clock;
   logic reset;
   logic       csr_write_enable;
   logic [1:0] csr_index;
   logic [7:0] csr_write_data;

   timu_req_if req_bus ();
   timu_rsp_if rsp_bus ();

   timer_and_interrupt_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_if           (req_bus),
      .rsp_if           (rsp_bus),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // model state and configuration
   logic [8:0]  div_prescaler;
   logic [10:0] tmr_prescaler;
   logic [7:0]  div_counter;
   logic [7:0]  tmr_counter;
   logic [4:0]  irq_flags;
   logic [2:0]  ctl_reg;
   logic [7:0]  modulo_reg;
   logic [4:0]  irq_enable_reg;

   timu_result_type step_results_due [$];
   plan_row_type    plan [$];

   int mismatch_count = 0;
   int steps_sent     = 0;
   int steps_checked  = 0;
   int irq_taken      = 0;
   int tmr_reloads    = 0;
   int settings_used  = 0;
   int clock_ticks    = 0;
   int burst_left     = 0;
   int gap_left       = 0;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // timer prescaler period for a rate code
   function automatic logic [10:0] tick_period(input logic [1:0] rate);
      logic [10:0] p;
      case (rate)
         RATE_16:  p = 11'd16;
         RATE_64:  p = 11'd64;
         RATE_256: p = 11'd256;
         default:  p = 11'd1024;
      endcase
      return p;
   endfunction

   // advance divider, timer and flags by one CPU step
   function automatic timu_result_type run_cpu_step(input logic [7:0] cyc, input logic me,
                                                    input logic [4:0] req);
      timu_result_type r;
      int src;
      r = '0;
      irq_flags = irq_flags | req;

      div_prescaler = div_prescaler + {1'b0, cyc};
      if (div_prescaler >= 9'd256) begin
         div_counter   = div_counter + 8'd1;
         div_prescaler = '0;
      end

      // prescaler holds while the timer is off
      if (ctl_reg[TIMER_ENABLE_BIT]) begin
         tmr_prescaler = tmr_prescaler + {3'b000, cyc};
         if (tmr_prescaler >= tick_period(ctl_reg[1:0])) begin
            tmr_prescaler = '0;
            if (tmr_counter == TIMER_OVERFLOW) begin
               tmr_counter = modulo_reg;
               irq_flags[TIMER_FLAG_BIT] = 1'b1;
               tmr_reloads++;
            end else begin
               tmr_counter = tmr_counter + 8'd1;
            end
         end
      end

      // lowest enabled pending source wins
      if (me) begin
         for (src = 0; src < SOURCE_COUNT; src++) begin
            if (!r.dispatch && irq_flags[src] && irq_enable_reg[src]) begin
               irq_flags[src]   = 1'b0;
               r.dispatch       = 1'b1;
               r.vector_address = VECTOR_BASE + 7'(src * 8);
               irq_taken++;
            end
         end
      end

      r.divider_value = div_counter;
      r.timer_value   = tmr_counter;
      r.flag_bits     = irq_flags;
      return r;
   endfunction

   function automatic plan_row_type step_row(input logic [7:0] cyc, input logic me,
                                             input logic [4:0] req);
      plan_row_type r;
      r.kind  = ROW_STEP;
      r.idx   = '0;
      r.val   = cyc;
      r.me    = me;
      r.req   = req;
      r.known = 1'b0;
      r.res   = '0;
      return r;
   endfunction

   function automatic plan_row_type known_row(input logic [7:0] cyc, input logic me,
                                              input logic [4:0] req,
                                              input timu_result_type res);
      plan_row_type r;
      r       = step_row(cyc, me, req);
      r.known = 1'b1;
      r.res   = res;
      return r;
   endfunction

   function automatic plan_row_type csr_row(input logic [1:0] idx, input logic [7:0] val);
      plan_row_type r;
      r      = step_row('0, 1'b0, '0);
      r.kind = ROW_CSR;
      r.idx  = idx;
      r.val  = val;
      return r;
   endfunction

   // one request; gaps come from the burst pattern
   task automatic send_step(input logic [7:0] cyc, input logic me, input logic [4:0] req,
                            input bit known, input timu_result_type res);
      timu_result_type due;
      bit taken;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 40);
         gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      end
      if (gap_left > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap_left) @(negedge clock);
         gap_left = 0;
      end
      req_bus.valid         <= 1'b1;
      req_bus.cycle_count   <= cyc;
      req_bus.master_enable <= me;
      req_bus.new_requests  <= req;
      taken = 1'b0;
      while (!taken) begin
         @(posedge clock);
         taken = req_bus.ready;
         if (taken) begin
            due = run_cpu_step(cyc, me, req);
            if (known) due = res;
            step_results_due.push_back(due);
            steps_sent++;
         end
         @(negedge clock);
      end
      burst_left--;
   endtask

   // let every outstanding result come back
   task automatic drain_steps();
      req_bus.valid <= 1'b0;
      while (step_results_due.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [7:0] val);
      csr_write_enable <= 1'b1;
      csr_index        <= idx;
      csr_write_data   <= val;
      @(posedge clock);
      case (idx)
         CSR_TIMER_CONTROL:    ctl_reg        = val[2:0];
         CSR_TIMER_MODULO:     modulo_reg     = val;
         CSR_INTERRUPT_ENABLE: irq_enable_reg = val[4:0];
         default: ;
      endcase
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   // response side stalls in modes of its own
   initial begin
      int mode;
      int span;
      int period;
      int k;
      rsp_bus.ready = 1'b0;
      forever begin
         mode   = $urandom_range(0, 3);
         span   = $urandom_range(20, 200);
         period = $urandom_range(2, 5);
         for (k = 0; k < span; k++) begin
            @(negedge clock);
            case (mode)
               0: rsp_bus.ready <= 1'b1;
               1: rsp_bus.ready <= ($urandom_range(0, 3) != 0);
               2: rsp_bus.ready <= ((k % period) != 0);
               default: rsp_bus.ready <= ($urandom_range(0, 3) == 0);
            endcase
         end
      end
   end

   // compare each result with the oldest prediction
   always @(posedge clock) begin
      timu_result_type want;
      timu_result_type got;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         got = '{rsp_bus.divider_value, rsp_bus.timer_value, rsp_bus.flag_bits,
                 rsp_bus.dispatch, rsp_bus.vector_address};
         if (step_results_due.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_LIMIT)
               $display("[%0t] unexpected result div=%h tmr=%h flags=%h disp=%b vec=%h",
                        $time, got.divider_value, got.timer_value, got.flag_bits,
                        got.dispatch, got.vector_address);
         end else begin
            want = step_results_due.pop_front();
            steps_checked++;
            if (got !== want) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_LIMIT)
                  $display({"[%0t] mismatch exp div=%h tmr=%h flags=%h disp=%b vec=%h",
                            " | got div=%h tmr=%h flags=%h disp=%b vec=%h"},
                           $time, want.divider_value, want.timer_value, want.flag_bits,
                           want.dispatch, want.vector_address, got.divider_value,
                           got.timer_value, got.flag_bits, got.dispatch,
                           got.vector_address);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      clock_ticks++;
      if (clock_ticks > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", clock_ticks,
                  step_results_due.size());
         $display("Simulation FAILED");
         $finish;
      end
   end

   initial begin
      int pick;
      logic [7:0] cyc;
      logic [7:0] data;

      reset                 = 1'b1;
      req_bus.valid         = 1'b0;
      req_bus.cycle_count   = '0;
      req_bus.master_enable = 1'b0;
      req_bus.new_requests  = '0;
      csr_write_enable      = 1'b0;
      csr_index             = '0;
      csr_write_data        = '0;
      div_prescaler  = '0;
      tmr_prescaler  = '0;
      div_counter    = '0;
      tmr_counter    = '0;
      irq_flags      = '0;
      ctl_reg        = '0;
      modulo_reg     = '0;
      irq_enable_reg = '0;

      // directed: reset state, divider edge, priority order, timer corners
      plan.push_back(known_row(8'd0,   1'b0, 5'h00, '{8'd0, 8'd0, 5'h00, 1'b0, 7'h00}));
      plan.push_back(known_row(8'd255, 1'b0, 5'h00, '{8'd0, 8'd0, 5'h00, 1'b0, 7'h00}));
      plan.push_back(known_row(8'd1,   1'b0, 5'h00, '{8'd1, 8'd0, 5'h00, 1'b0, 7'h00}));
      // all flags pending, nothing enabled
      plan.push_back(known_row(8'd0,   1'b1, 5'h1F, '{8'd1, 8'd0, 5'h1F, 1'b0, 7'h00}));
      plan.push_back(csr_row(CSR_INTERRUPT_ENABLE, 8'hFF));
      // master enable off keeps flags
      plan.push_back(known_row(8'd0,   1'b0, 5'h00, '{8'd1, 8'd0, 5'h1F, 1'b0, 7'h00}));
      plan.push_back(known_row(8'd0,   1'b1, 5'h00, '{8'd1, 8'd0, 5'h1E, 1'b1, 7'h40}));
      plan.push_back(known_row(8'd0,   1'b1, 5'h00, '{8'd1, 8'd0, 5'h1C, 1'b1, 7'h48}));
      plan.push_back(known_row(8'd0,   1'b1, 5'h00, '{8'd1, 8'd0, 5'h18, 1'b1, 7'h50}));
      plan.push_back(known_row(8'd0,   1'b1, 5'h00, '{8'd1, 8'd0, 5'h10, 1'b1, 7'h58}));
      plan.push_back(known_row(8'd0,   1'b1, 5'h00, '{8'd1, 8'd0, 5'h00, 1'b1, 7'h60}));
      plan.push_back(known_row(8'd0,   1'b1, 5'h00, '{8'd1, 8'd0, 5'h00, 1'b0, 7'h00}));
      plan.push_back(csr_row(CSR_TIMER_MODULO, 8'hFF));
      plan.push_back(csr_row(CSR_TIMER_CONTROL, 8'hFD));
      plan.push_back(step_row(8'd15,  1'b0, 5'h00));
      plan.push_back(step_row(8'd1,   1'b0, 5'h00));
      plan.push_back(step_row(8'd255, 1'b1, 5'h04));
      // slow rate, then faster rate while the prescaler holds a large count
      plan.push_back(csr_row(CSR_TIMER_CONTROL, {5'd0, 1'b1, RATE_1024}));
      plan.push_back(step_row(8'd255, 1'b0, 5'h00));
      plan.push_back(step_row(8'd255, 1'b0, 5'h00));
      plan.push_back(step_row(8'd255, 1'b0, 5'h00));
      plan.push_back(step_row(8'd255, 1'b0, 5'h00));
      plan.push_back(csr_row(CSR_TIMER_CONTROL, {5'd0, 1'b1, RATE_256}));
      plan.push_back(step_row(8'd0,   1'b0, 5'h00));
      // timer off: prescaler must hold
      plan.push_back(csr_row(CSR_TIMER_CONTROL, {5'd0, 1'b0, RATE_256}));
      plan.push_back(step_row(8'd200, 1'b0, 5'h00));
      plan.push_back(csr_row(CSR_UNMAPPED, 8'hFF));
      plan.push_back(csr_row(CSR_TIMER_CONTROL, {5'd0, 1'b1, RATE_64}));
      plan.push_back(step_row(8'd100, 1'b1, 5'h12));
      plan.push_back(step_row(8'd64,  1'b1, 5'h00));
      plan.push_back(step_row(8'd255, 1'b1, 5'h09));
      plan.push_back(csr_row(CSR_INTERRUPT_ENABLE, 8'h00));
      plan.push_back(step_row(8'd0,   1'b1, 5'h1F));

      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (plan[i]) begin
         if (plan[i].kind == ROW_CSR) begin
            drain_steps();
            csr_write(plan[i].idx, plan[i].val);
         end else begin
            send_step(plan[i].val, plan[i].me, plan[i].req, plan[i].known, plan[i].res);
         end
      end

      // random phases, each under a fresh setting
      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain_steps();
         data = 8'($urandom_range(0, 255));
         if (ph < 8) data[2:0] = 3'(ph);
         csr_write(CSR_TIMER_CONTROL, data);
         case (ph % 4)
            0: data = 8'h00;
            1: data = 8'hFF;
            2: data = 8'hFE;
            default: data = 8'($urandom_range(0, 255));
         endcase
         csr_write(CSR_TIMER_MODULO, data);
         data = 8'($urandom_range(0, 255));
         case (ph % 3)
            0: data[4:0] = 5'h1F;
            2: data[4:0] = 5'h00;
            default: ;
         endcase
         csr_write(CSR_INTERRUPT_ENABLE, data);
         if ($urandom_range(0, 1) == 0)
            csr_write(CSR_UNMAPPED, 8'($urandom_range(0, 255)));
         settings_used++;

         for (int n = 0; n < PHASE_STEPS; n++) begin
            pick = $urandom_range(0, 9);
            case (pick)
               0: cyc = 8'd0;
               1: cyc = 8'd255;
               2, 3, 4: cyc = 8'($urandom_range(1, 20));
               default: cyc = 8'($urandom_range(0, 255));
            endcase
            send_step(cyc, ($urandom_range(0, 3) != 0),
                      ($urandom_range(0, 5) == 0) ? 5'($urandom_range(0, 31)) : 5'h00,
                      1'b0, '0);
         end
      end

      drain_steps();
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("checked %0d of %0d CPU steps over %0d random timer settings plus directed rows",
               steps_checked, steps_sent, settings_used);
      $display("model saw %0d interrupts taken and %0d timer reloads; %0d mismatches",
               irq_taken, tmr_reloads, mismatch_count);
      if (mismatch_count == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end

endmodule

// ===== filelist.f =====
design/timu_pkg.sv
design/timu_if.sv
design/timu_core.sv
design/timu_out_queue.sv
design/timer_and_interrupt_unit.sv
verif/tb.sv
